### sv/adar_pkg.sv
// Shared types, constants and helper functions of the attitude-difference rate block.
package adar_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROD,
    S_ENTRY,
    S_MAC,
    S_SCALE,
    S_DIV,
    S_FIN,
    S_DONE
  } seq_state_e;

  localparam int unsigned NUM_ENTRIES = 9;
  localparam int unsigned RAM_DEPTH   = 2 * NUM_ENTRIES;
  localparam int unsigned RAM_AW      = $clog2(RAM_DEPTH);
  localparam int unsigned ENTRY_W     = 18;
  localparam int unsigned PRODQ_W     = 32;
  localparam int unsigned SUM_W       = 36;
  localparam int unsigned RND_W       = 22;
  localparam int unsigned DIFF_W      = 19;
  localparam int unsigned ACC_W       = 39;
  localparam int unsigned MUL_AW      = 38;
  localparam int unsigned MUL_BW      = 19;
  localparam int unsigned MUL_PW      = 57;
  localparam int unsigned NUM_W       = 43;
  localparam int unsigned DEN_W       = 33;
  localparam int unsigned RATE_W      = 32;
  localparam int unsigned CNT_W       = 6;

  localparam int unsigned PROD_LAST  = 9;
  localparam int unsigned ENTRY_LAST = 8;
  localparam int unsigned SCALE_LAST = 1;
  localparam int unsigned DIV_LAST   = 31;

  localparam logic signed [ENTRY_W-1:0] ENTRY_ONE = 18'sd65536;
  localparam logic signed [ENTRY_W-1:0] ENTRY_MAX = 18'sd131071;
  localparam logic signed [ENTRY_W-1:0] ENTRY_MIN = -18'sd131072;
  localparam logic signed [SUM_W-1:0]   ONE_Q30   = 36'sd1073741824;
  localparam logic signed [SUM_W-1:0]   RND_HALF  = 36'sd8192;
  localparam logic signed [MUL_BW-1:0]  SCALE_MUL = 19'sd15625;
  localparam logic [RATE_W-1:0]         RATE_MAX  = 32'h7FFF_FFFF;
  localparam logic [RATE_W-1:0]         RATE_MIN  = 32'h8000_0000;

  localparam logic [1:0] RATE_X = 2'd0;
  localparam logic [1:0] RATE_Y = 2'd1;
  localparam logic [1:0] RATE_Z = 2'd2;

  function automatic logic [1:0] row_i(input logic [1:0] rsel);
    logic [1:0] r;
    case (rsel)
      RATE_X:  r = 2'd2;
      RATE_Y:  r = 2'd0;
      default: r = 2'd1;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] row_j(input logic [1:0] rsel);
    logic [1:0] r;
    case (rsel)
      RATE_X:  r = 2'd1;
      RATE_Y:  r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] mat_idx(input logic [1:0] row, input logic [1:0] col);
    return {2'b00, row} * 4'd3 + {2'b00, col};
  endfunction

  function automatic logic [RAM_AW-1:0] ram_addr(input logic bank, input logic [3:0] idx);
    return bank ? RAM_AW'(idx) + RAM_AW'(NUM_ENTRIES) : RAM_AW'(idx);
  endfunction

  function automatic logic signed [ENTRY_W-1:0] ident_entry(input logic [3:0] idx);
    return (idx == 4'd0 || idx == 4'd4 || idx == 4'd8) ? ENTRY_ONE : '0;
  endfunction

endpackage

### sv/adar_ram.sv
// Generic RAM with one write port and two registered read ports.
module adar_ram #(
  parameter int unsigned WIDTH = 18,
  parameter int unsigned DEPTH = 18,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

### sv/attitude_diff_angular_rate_core.sv
// Top level of the attitude-difference angular rate estimator.
//
// An input item carries a microsecond stamp and a Q1.15 quaternion. It is accepted when
// in_valid_i is high and in_stall_o is low. The block turns the quaternion into a Q2.16
// rotation matrix and forms the body rates (R - R_prev) / dt * R^T as Q16.16 values.
// One shared multiplier and a radix-2 divider that retires one quotient bit per cycle
// do all the arithmetic under a small sequencer, and in_stall_o stays high while an
// item is in work. When a rate is computed, the sequencer builds the matrix and then
// forms each of the three rates in turn, ending each in the divider; when dt does not
// exceed the minimum interval, it builds the matrix only and skips the rates.
// The next item can be accepted in the cycle after the result is registered.
// The result is held in an output register until out_stall_i is low; while it waits,
// the next item is accepted and processed, and the block then waits with its new
// result until the register is free.
// The single configuration register takes a write whenever cfg_valid_i is high and is
// to be written only while the block is idle. Reset sets the minimum interval to one
// microsecond, the previous rotation to identity and marks no item as seen yet.
module attitude_diff_angular_rate_core import adar_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [9:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [31:0]        stamp_us_i,
  input  logic signed [15:0] quat_w_i,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] rate_x_o,
  output logic signed [31:0] rate_y_o,
  output logic signed [31:0] rate_z_o,
  output logic               rate_valid_o
);

  seq_state_e state_q, state_d;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [1:0]       k_q, k_d;
  logic [1:0]       ph_q, ph_d;
  logic [1:0]       rsel_q, rsel_d;
  logic [9:0]       min_q, min_d;
  logic [31:0]      prev_stamp_q, prev_stamp_d;
  logic             seen_q, seen_d;
  logic             prev_ok_q, prev_ok_d;
  logic             bank_q, bank_d;
  logic [31:0]      dt_q, dt_d;
  logic             rvalid_q, rvalid_d;
  logic             out_valid_q, out_valid_d;

  logic signed [15:0] qw_q, qw_d, qx_q, qx_d, qy_q, qy_d, qz_q, qz_d;
  logic signed [PRODQ_W-1:0] prod_q [NUM_ENTRIES];
  logic signed [PRODQ_W-1:0] prod_d [NUM_ENTRIES];
  logic signed [MUL_PW-1:0]  m_q, m_d;
  logic signed [DIFF_W-1:0]  diff_q, diff_d;
  logic signed [ACC_W-1:0]   acc_q, acc_d;
  logic                      neg_q, neg_d;
  logic                      ovf_q, ovf_d;
  logic [DEN_W-1:0]          rem_q, rem_d;
  logic [31:0]               quo_q, quo_d;
  logic [RATE_W-1:0]         rate_q [3];
  logic [RATE_W-1:0]         rate_d [3];
  logic [RATE_W-1:0]         out_x_q, out_x_d, out_y_q, out_y_d, out_z_q, out_z_d;
  logic                      out_rv_q, out_rv_d;

  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  logic                     ram_we;
  logic [RAM_AW-1:0]        ram_waddr, ram_raddr_a, ram_raddr_b;
  logic [ENTRY_W-1:0]       ram_wdata, ram_rdata_a, ram_rdata_b;

  logic                      in_accept;
  logic                      out_free;
  logic [3:0]                idx_ik, idx_jk;
  logic signed [SUM_W-1:0]   ent_pa, ent_pb, ent_sum, ent_v, ent_t;
  logic signed [RND_W-1:0]   ent_r;
  logic signed [ENTRY_W-1:0] ent_q16;
  logic                      ent_diag, ent_sub;
  logic signed [ACC_W-1:0]   acc_abs;
  logic [NUM_W-1:0]          num;
  logic [DEN_W-1:0]          den;
  logic [DEN_W:0]            div_shift;
  logic [DEN_W+1:0]          div_trial;
  logic                      div_ge;
  logic [RATE_W-1:0]         rate_sat;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;

  assign idx_ik = mat_idx(row_i(rsel_q), k_q);
  assign idx_jk = mat_idx(row_j(rsel_q), k_q);

  adar_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(RAM_DEPTH)
  ) u_rot_ram (
    .clk_i    (clk_i),
    .we_i     (ram_we),
    .waddr_i  (ram_waddr),
    .wdata_i  (ram_wdata),
    .raddr_a_i(ram_raddr_a),
    .raddr_b_i(ram_raddr_b),
    .rdata_a_o(ram_rdata_a),
    .rdata_b_o(ram_rdata_b)
  );

  always_comb begin
    ent_pa   = '0;
    ent_pb   = '0;
    ent_diag = 1'b0;
    ent_sub  = 1'b0;
    case (cnt_q[3:0])
      4'd0: begin
        ent_pa = SUM_W'(prod_q[1]); ent_pb = SUM_W'(prod_q[2]); ent_diag = 1'b1;
      end
      4'd1: begin
        ent_pa = SUM_W'(prod_q[3]); ent_pb = SUM_W'(prod_q[8]); ent_sub = 1'b1;
      end
      4'd2: begin
        ent_pa = SUM_W'(prod_q[4]); ent_pb = SUM_W'(prod_q[7]);
      end
      4'd3: begin
        ent_pa = SUM_W'(prod_q[3]); ent_pb = SUM_W'(prod_q[8]);
      end
      4'd4: begin
        ent_pa = SUM_W'(prod_q[0]); ent_pb = SUM_W'(prod_q[2]); ent_diag = 1'b1;
      end
      4'd5: begin
        ent_pa = SUM_W'(prod_q[5]); ent_pb = SUM_W'(prod_q[6]); ent_sub = 1'b1;
      end
      4'd6: begin
        ent_pa = SUM_W'(prod_q[4]); ent_pb = SUM_W'(prod_q[7]); ent_sub = 1'b1;
      end
      4'd7: begin
        ent_pa = SUM_W'(prod_q[5]); ent_pb = SUM_W'(prod_q[6]);
      end
      4'd8: begin
        ent_pa = SUM_W'(prod_q[0]); ent_pb = SUM_W'(prod_q[1]); ent_diag = 1'b1;
      end
      default: begin
        ent_pa = '0;
      end
    endcase
    ent_sum = ent_sub ? ent_pa - ent_pb : ent_pa + ent_pb;
    ent_v   = ent_diag ? ONE_Q30 - (ent_sum <<< 1) : (ent_sum <<< 1);
    ent_t   = ent_v + RND_HALF;
    ent_r   = RND_W'(ent_t >>> 14);
    if (ent_r > RND_W'(ENTRY_MAX)) begin
      ent_q16 = ENTRY_MAX;
    end else if (ent_r < RND_W'(ENTRY_MIN)) begin
      ent_q16 = ENTRY_MIN;
    end else begin
      ent_q16 = ENTRY_W'(ent_r);
    end
  end

  assign acc_abs   = acc_q[ACC_W-1] ? -acc_q : acc_q;
  assign num       = NUM_W'(m_q[51:9]) + NUM_W'(dt_q);
  assign den       = {dt_q, 1'b0};
  assign div_shift = {rem_q, quo_q[31]};
  assign div_trial = {1'b0, div_shift} - {2'b00, den};
  assign div_ge    = !div_trial[DEN_W+1];

  always_comb begin
    if (ovf_q) begin
      rate_sat = neg_q ? RATE_MIN : RATE_MAX;
    end else if (neg_q) begin
      rate_sat = (quo_q > RATE_MIN) ? RATE_MIN : (~quo_q + 32'd1);
    end else begin
      rate_sat = quo_q[31] ? RATE_MAX : quo_q;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_accept) state_d = S_PROD;
      end
      S_PROD: begin
        if (cnt_q == CNT_W'(PROD_LAST)) state_d = S_ENTRY;
      end
      S_ENTRY: begin
        if (cnt_q == CNT_W'(ENTRY_LAST)) state_d = rvalid_q ? S_MAC : S_DONE;
      end
      S_MAC: begin
        if (k_q == 2'd2 && ph_q == 2'd3) state_d = S_SCALE;
      end
      S_SCALE: begin
        if (cnt_q == CNT_W'(SCALE_LAST)) state_d = S_DIV;
      end
      S_DIV: begin
        if (cnt_q == CNT_W'(DIV_LAST)) state_d = S_FIN;
      end
      S_FIN: begin
        state_d = (rsel_q == RATE_Z) ? S_DONE : S_MAC;
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    mul_a       = '0;
    mul_b       = '0;
    ram_we      = 1'b0;
    ram_waddr   = ram_addr(bank_q, cnt_q[3:0]);
    ram_wdata   = ent_q16;
    ram_raddr_a = ram_addr(bank_q, idx_ik);
    ram_raddr_b = ram_addr(!bank_q, idx_ik);
    case (state_q)
      S_PROD: begin
        case (cnt_q[3:0])
          4'd0:    begin mul_a = MUL_AW'(qx_q); mul_b = MUL_BW'(qx_q); end
          4'd1:    begin mul_a = MUL_AW'(qy_q); mul_b = MUL_BW'(qy_q); end
          4'd2:    begin mul_a = MUL_AW'(qz_q); mul_b = MUL_BW'(qz_q); end
          4'd3:    begin mul_a = MUL_AW'(qx_q); mul_b = MUL_BW'(qy_q); end
          4'd4:    begin mul_a = MUL_AW'(qx_q); mul_b = MUL_BW'(qz_q); end
          4'd5:    begin mul_a = MUL_AW'(qy_q); mul_b = MUL_BW'(qz_q); end
          4'd6:    begin mul_a = MUL_AW'(qw_q); mul_b = MUL_BW'(qx_q); end
          4'd7:    begin mul_a = MUL_AW'(qw_q); mul_b = MUL_BW'(qy_q); end
          4'd8:    begin mul_a = MUL_AW'(qw_q); mul_b = MUL_BW'(qz_q); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      S_ENTRY: begin
        ram_we = 1'b1;
      end
      S_MAC: begin
        if (ph_q == 2'd1) begin
          ram_raddr_a = ram_addr(bank_q, idx_jk);
        end
        mul_a = MUL_AW'(diff_q);
        mul_b = MUL_BW'($signed(ram_rdata_a));
      end
      S_SCALE: begin
        mul_a = MUL_AW'(acc_abs);
        mul_b = SCALE_MUL;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  always_comb begin
    cnt_d        = (state_d != state_q) ? '0 : cnt_q + CNT_W'(1);
    k_d          = k_q;
    ph_d         = ph_q;
    rsel_d       = rsel_q;
    min_d        = cfg_valid_i ? cfg_data_i : min_q;
    prev_stamp_d = prev_stamp_q;
    seen_d       = seen_q;
    prev_ok_d    = prev_ok_q;
    bank_d       = bank_q;
    dt_d         = dt_q;
    rvalid_d     = rvalid_q;
    out_valid_d  = out_valid_q;
    qw_d         = qw_q;
    qx_d         = qx_q;
    qy_d         = qy_q;
    qz_d         = qz_q;
    prod_d       = prod_q;
    m_d          = mul_a * mul_b;
    diff_d       = diff_q;
    acc_d        = acc_q;
    neg_d        = neg_q;
    ovf_d        = ovf_q;
    rem_d        = rem_q;
    quo_d        = quo_q;
    rate_d       = rate_q;
    out_x_d      = out_x_q;
    out_y_d      = out_y_q;
    out_z_d      = out_z_q;
    out_rv_d     = out_rv_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          qw_d         = quat_w_i;
          qx_d         = quat_x_i;
          qy_d         = quat_y_i;
          qz_d         = quat_z_i;
          dt_d         = seen_q ? stamp_us_i - prev_stamp_q : '0;
          rvalid_d     = (seen_q ? stamp_us_i - prev_stamp_q : '0) > {22'b0, min_q};
          prev_stamp_d = stamp_us_i;
          prev_ok_d    = seen_q;
          seen_d       = 1'b1;
          rsel_d       = RATE_X;
          rate_d[0]    = '0;
          rate_d[1]    = '0;
          rate_d[2]    = '0;
        end
      end
      S_PROD: begin
        if (cnt_q != '0) begin
          for (int unsigned i = 0; i < NUM_ENTRIES - 1; i++) begin
            prod_d[i] = prod_q[i+1];
          end
          prod_d[NUM_ENTRIES-1] = PRODQ_W'(m_q);
        end
      end
      S_MAC: begin
        ph_d = ph_q + 2'd1;
        if (ph_q == 2'd3) begin
          k_d   = k_q + 2'd1;
          acc_d = acc_q + ACC_W'(m_q);
        end
        if (ph_q == 2'd1) begin
          diff_d = DIFF_W'($signed(ram_rdata_a))
                 - (prev_ok_q ? DIFF_W'($signed(ram_rdata_b)) : DIFF_W'(ident_entry(idx_ik)));
        end
      end
      S_SCALE: begin
        if (cnt_q == '0) begin
          neg_d = acc_q[ACC_W-1];
        end else begin
          rem_d = DEN_W'(num[NUM_W-1:32]);
          quo_d = num[31:0];
          ovf_d = DEN_W'(num[NUM_W-1:32]) >= den;
        end
      end
      S_DIV: begin
        rem_d = div_ge ? div_trial[DEN_W-1:0] : div_shift[DEN_W-1:0];
        quo_d = {quo_q[30:0], div_ge};
      end
      S_FIN: begin
        rate_d[rsel_q] = rate_sat;
        rsel_d         = rsel_q + 2'd1;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_x_d     = rate_q[0];
          out_y_d     = rate_q[1];
          out_z_d     = rate_q[2];
          out_rv_d    = rvalid_q;
          bank_d      = !bank_q;
        end
      end
      default: begin
        out_rv_d = out_rv_q;
      end
    endcase

    if (state_d == S_MAC && state_q != S_MAC) begin
      k_d   = '0;
      ph_d  = '0;
      acc_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      k_q          <= '0;
      ph_q         <= '0;
      rsel_q       <= RATE_X;
      min_q        <= 10'd1;
      prev_stamp_q <= '0;
      seen_q       <= 1'b0;
      prev_ok_q    <= 1'b0;
      bank_q       <= 1'b0;
      rvalid_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      k_q          <= k_d;
      ph_q         <= ph_d;
      rsel_q       <= rsel_d;
      min_q        <= min_d;
      prev_stamp_q <= prev_stamp_d;
      seen_q       <= seen_d;
      prev_ok_q    <= prev_ok_d;
      bank_q       <= bank_d;
      rvalid_q     <= rvalid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dt_q     <= dt_d;
    qw_q     <= qw_d;
    qx_q     <= qx_d;
    qy_q     <= qy_d;
    qz_q     <= qz_d;
    prod_q   <= prod_d;
    m_q      <= m_d;
    diff_q   <= diff_d;
    acc_q    <= acc_d;
    neg_q    <= neg_d;
    ovf_q    <= ovf_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    rate_q   <= rate_d;
    out_x_q  <= out_x_d;
    out_y_q  <= out_y_d;
    out_z_q  <= out_z_d;
    out_rv_q <= out_rv_d;
  end

  assign out_valid_o  = out_valid_q;
  assign rate_x_o     = $signed(out_x_q);
  assign rate_y_o     = $signed(out_y_q);
  assign rate_z_o     = $signed(out_z_q);
  assign rate_valid_o = out_rv_q;

endmodule

### sv/adar_checker.sv
// Port-level checks of the attitude-difference rate block and their binding.
module adar_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [31:0] rate_x_o,
  input logic signed [31:0] rate_y_o,
  input logic signed [31:0] rate_z_o,
  input logic               rate_valid_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("Result withdrawn while stalled.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(rate_x_o) && $stable(rate_y_o)
                                   && $stable(rate_z_o) && $stable(rate_valid_o))
    else $error("Result changed while stalled.");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !rate_valid_o |-> rate_x_o == 0 && rate_y_o == 0 && rate_z_o == 0)
    else $error("Rates not zero on an item without a computed rate.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o ##1 in_stall_o)
    else $error("Input taken again while an item is in work.");

endmodule

bind attitude_diff_angular_rate_core adar_checker u_adar_checker (.*);

### sim/attitude_diff_angular_rate_core_test.sv
// Self-checking testbench for the attitude-difference angular rate core with a rate predictor.
`timescale 1ns / 1ps

typedef struct {
  logic signed [31:0] x;
  logic signed [31:0] y;
  logic signed [31:0] z;
  logic               valid;
} rate_t;

class rate_tracker;
  int          rot_prev[9];
  logic [31:0] stamp_prev;
  bit          have_prev;
  int unsigned min_interval;
  rate_t       pending_rates[$];
  int          errors;

  function new();
    for (int k = 0; k < 9; k++) rot_prev[k] = (k % 4 == 0) ? 65536 : 0;
    stamp_prev   = '0;
    have_prev    = 1'b0;
    min_interval = 1;
    errors       = 0;
  endfunction

  function int to_q2_16(longint v30);
    longint r;
    r = (v30 + 64'sd8192) >>> 14;
    if (r > 131071) r = 131071;
    else if (r < -131072) r = -131072;
    return int'(r);
  endfunction

  function logic signed [31:0] skew_rate(input int cur[9], input int i, input int j,
                                         input logic [31:0] dt);
    longint s;
    longint r;
    longint unsigned n, d, q;
    s = 0;
    for (int k = 0; k < 3; k++)
      s += longint'(cur[i*3+k] - rot_prev[i*3+k]) * longint'(cur[j*3+k]);
    n = longint'(s < 0 ? -s : s) * 64'd1000000;
    d = 64'(dt) * 64'd65536;
    q = (64'd2 * n + d) / (64'd2 * d);
    if (s < 0) begin
      if (q > 64'd2147483648) q = 64'd2147483648;
      r = -longint'(q);
    end else begin
      if (q > 64'd2147483647) q = 64'd2147483647;
      r = longint'(q);
    end
    return r[31:0];
  endfunction

  function void take_sample(input logic [31:0] stamp, input logic signed [15:0] qw,
                            input logic signed [15:0] qx, input logic signed [15:0] qy,
                            input logic signed [15:0] qz);
    longint w, x, y, z, one;
    int rot[9];
    logic [31:0] dt;
    rate_t want;
    w = qw;
    x = qx;
    y = qy;
    z = qz;
    one = longint'(1) << 30;
    rot[0] = to_q2_16(one - 2 * (y * y + z * z));
    rot[1] = to_q2_16(2 * (x * y - w * z));
    rot[2] = to_q2_16(2 * (x * z + w * y));
    rot[3] = to_q2_16(2 * (x * y + w * z));
    rot[4] = to_q2_16(one - 2 * (x * x + z * z));
    rot[5] = to_q2_16(2 * (y * z - w * x));
    rot[6] = to_q2_16(2 * (x * z - w * y));
    rot[7] = to_q2_16(2 * (y * z + w * x));
    rot[8] = to_q2_16(one - 2 * (x * x + y * y));
    dt = have_prev ? stamp - stamp_prev : 32'd0;
    want.x = '0;
    want.y = '0;
    want.z = '0;
    want.valid = 1'b0;
    if (dt > min_interval) begin
      want.valid = 1'b1;
      want.x = skew_rate(rot, 2, 1, dt);
      want.y = skew_rate(rot, 0, 2, dt);
      want.z = skew_rate(rot, 1, 0, dt);
    end
    pending_rates.push_back(want);
    for (int k = 0; k < 9; k++) rot_prev[k] = rot[k];
    stamp_prev = stamp;
    have_prev  = 1'b1;
  endfunction

  function void compare_rate(input rate_t got);
    rate_t want;
    if (pending_rates.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("Unexpected item: x=%0d y=%0d z=%0d valid=%0b",
                 got.x, got.y, got.z, got.valid);
      return;
    end
    want = pending_rates.pop_front();
    if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
        got.valid !== want.valid) begin
      errors++;
      if (errors <= 10)
        $display("Mismatch: expected x=%0d y=%0d z=%0d valid=%0b, got x=%0d y=%0d z=%0d valid=%0b",
                 want.x, want.y, want.z, want.valid, got.x, got.y, got.z, got.valid);
    end
  endfunction
endclass

module attitude_diff_angular_rate_core_test;

  localparam int unsigned CYCLE_LIMIT = 1500000;
  localparam int RANDOM_PER_PHASE = 215;
  localparam logic signed [15:0] QUAT_EXTREMES[6] = '{-16'sd32768, -16'sd32767, -16'sd1,
                                                      16'sd0, 16'sd1, 16'sd32767};

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [9:0]         cfg_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [31:0]        stamp_us_i;
  logic signed [15:0] quat_w_i;
  logic signed [15:0] quat_x_i;
  logic signed [15:0] quat_y_i;
  logic signed [15:0] quat_z_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [31:0] rate_x_o;
  logic signed [31:0] rate_y_o;
  logic signed [31:0] rate_z_o;
  logic               rate_valid_o;

  rate_tracker        tracker = new();
  bit                 in_quiet = 1'b0;
  bit                 out_quiet = 1'b0;
  int                 cur_min = 1;
  logic [31:0]        last_stamp = '0;
  real                uq[4] = '{1.0, 0.0, 0.0, 0.0};
  logic signed [15:0] qv[4];
  int unsigned        cycle_count = 0;

  attitude_diff_angular_rate_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .stamp_us_i  (stamp_us_i),
    .quat_w_i    (quat_w_i),
    .quat_x_i    (quat_x_i),
    .quat_y_i    (quat_y_i),
    .quat_z_i    (quat_z_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .rate_x_o    (rate_x_o),
    .rate_y_o    (rate_y_o),
    .rate_z_o    (rate_z_o),
    .rate_valid_o(rate_valid_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic real rand_unit();
    return (real'($urandom_range(0, 65535)) - 32768.0) / 32768.0;
  endfunction

  function automatic logic signed [15:0] to_q15(real v);
    return 16'(int'(v * 32767.0));
  endfunction

  function automatic void normalize_uq();
    real nrm;
    nrm = $sqrt(uq[0] * uq[0] + uq[1] * uq[1] + uq[2] * uq[2] + uq[3] * uq[3]);
    if (nrm < 1.0e-6) begin
      uq = '{1.0, 0.0, 0.0, 0.0};
    end else begin
      for (int k = 0; k < 4; k++) uq[k] = uq[k] / nrm;
    end
  endfunction

  task automatic draw_quat();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) begin
      for (int k = 0; k < 4; k++) uq[k] = uq[k] + 0.05 * rand_unit();
      normalize_uq();
      for (int k = 0; k < 4; k++) qv[k] = to_q15(uq[k]);
    end else if (sel < 70) begin
      for (int k = 0; k < 4; k++) uq[k] = rand_unit();
      normalize_uq();
      for (int k = 0; k < 4; k++) qv[k] = to_q15(uq[k]);
    end else if (sel < 90) begin
      for (int k = 0; k < 4; k++) qv[k] = 16'($urandom());
    end else begin
      for (int k = 0; k < 4; k++) qv[k] = QUAT_EXTREMES[$urandom_range(0, 5)];
    end
  endtask

  task automatic send_item(input logic [31:0] stamp, input logic signed [15:0] qw,
                           input logic signed [15:0] qx, input logic signed [15:0] qy,
                           input logic signed [15:0] qz);
    int gap;
    gap = in_quiet ? 0 : $urandom_range(0, 15);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    stamp_us_i <= stamp;
    quat_w_i   <= qw;
    quat_x_i   <= qx;
    quat_y_i   <= qy;
    quat_z_i   <= qz;
    do @(posedge clk_i); while (in_stall_o);
    tracker.take_sample(stamp, qw, qx, qy, qz);
    last_stamp = stamp;
  endtask

  task automatic send_smooth_item(input logic [31:0] dt);
    for (int k = 0; k < 4; k++) uq[k] = uq[k] + 0.05 * rand_unit();
    normalize_uq();
    send_item(last_stamp + dt, to_q15(uq[0]), to_q15(uq[1]), to_q15(uq[2]), to_q15(uq[3]));
  endtask

  task automatic send_random_item();
    int sel;
    int dt;
    logic [31:0] stamp;
    sel = $urandom_range(0, 99);
    if (sel < 25) begin
      dt = cur_min + int'($urandom_range(0, 6)) - 3;
      if (dt < 0) dt = 0;
      stamp = last_stamp + 32'(dt);
    end else if (sel < 65) begin
      stamp = last_stamp + $urandom_range(1, 20000);
    end else if (sel < 80) begin
      stamp = last_stamp + $urandom_range(0, 2000);
    end else if (sel < 90) begin
      stamp = last_stamp + $urandom_range(20000, 5000000);
    end else begin
      stamp = $urandom();
    end
    draw_quat();
    send_item(stamp, qv[0], qv[1], qv[2], qv[3]);
  endtask

  task automatic hold_off();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (tracker.pending_rates.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_min_interval(input int value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= 10'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.min_interval = value;
    cur_min = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : result_drain
    int hold;
    rate_t got;
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      hold = out_quiet ? 0 : $urandom_range(0, 15);
      @(negedge clk_i);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      got.x     = rate_x_o;
      got.y     = rate_y_o;
      got.z     = rate_z_o;
      got.valid = rate_valid_o;
      tracker.compare_rate(got);
    end
  end

  initial begin : stimulus
    int min_settings[6];
    min_settings = '{0, 1023, 1000, 1, 37, 0};
    min_settings[5] = $urandom_range(0, 1023);
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    stamp_us_i  = '0;
    quat_w_i    = '0;
    quat_x_i    = '0;
    quat_y_i    = '0;
    quat_z_i    = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_item(32'd1000, 16'sd32767, 16'sd0, 16'sd0, 16'sd0);
    send_item(32'd1001, 16'sd32767, 16'sd0, 16'sd0, 16'sd0);
    send_item(32'd1003, 16'sd23170, 16'sd0, 16'sd0, 16'sd23170);
    send_item(32'd1005, 16'sd32767, 16'sd0, 16'sd0, 16'sd0);
    send_item(32'd1007, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
    send_item(32'd2007, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
    send_item(32'd2009, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767);
    send_item(32'd3009, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_item(32'd4009, 16'sd0, 16'sd32767, 16'sd0, 16'sd0);
    send_item(32'd5009, 16'sd0, 16'sd0, 16'sd32767, 16'sd0);
    send_item(32'd6009, 16'sd0, 16'sd0, 16'sd0, 16'sd32767);
    send_item(32'd6011, 16'sd0, 16'sd0, 16'sd0, -16'sd32768);
    send_item(32'd6013, -16'sd32768, 16'sd0, 16'sd0, 16'sd0);
    send_item(32'hFFFF_FFF0, 16'sd30000, 16'sd5000, -16'sd8000, 16'sd9000);
    send_item(32'h0000_0010, 16'sd30000, 16'sd5200, -16'sd8000, 16'sd9100);
    send_item(32'h0000_0005, 16'sd30000, 16'sd5000, -16'sd8000, 16'sd9000);
    send_item(32'h0000_0005, 16'sd0, 16'sd0, 16'sd0, 16'sd32767);
    send_item(32'h000F_4245, 16'sd32767, 16'sd100, -16'sd100, 16'sd50);

    for (int p = 0; p < 6; p++) begin
      hold_off();
      set_min_interval(min_settings[p]);
      send_smooth_item(32'(cur_min));
      send_smooth_item(32'(cur_min + 1));
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (n % 40 == 0) begin
          in_quiet  = ($urandom_range(0, 3) == 0);
          out_quiet = ($urandom_range(0, 3) == 0);
        end
        if ($urandom_range(0, 149) == 0) hold_off();
        send_random_item();
      end
    end

    hold_off();
    repeat (200) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.pending_rates.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
